// ----- rtl/melkman_polyline_hull_core_defines.svh -----
// Assertion macros for the polyline hull core.
`ifndef MELKMAN_POLYLINE_HULL_CORE_DEFINES_SVH
`define MELKMAN_POLYLINE_HULL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MPH_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MPH_ASSERT(label, clk, rst_n, prop)
`define MPH_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- rtl/mph_pkg.sv -----
// Shared types and constants for the polyline hull core.
package mph_pkg;
    localparam int unsigned ResultLimit = 64;
    localparam int unsigned ShortRun = 5;
    localparam int unsigned SeedCount = 3;

    typedef logic [31:0] point_t;

    function automatic logic signed [33:0] cross_half(input logic signed [16:0] d1,
                                                       input logic signed [16:0] d2);
        return 34'(d1) * 34'(d2);
    endfunction
endpackage

// ----- rtl/melkman_polyline_hull_core.sv -----
// Melkman convex hull of a streamed polyline, deque kept in a synchronous memory.
// The first two points and a dropped point are only stored or counted, the third seeds the
// deque, and each later point is skipped or pops entries and is pushed at both ends; each
// side test runs two memory reads, operand load, multiply, subtract and decision on one port.
// A last point then outputs its n results, one per cycle, n at most 64.
// Reset clears all control state and the tolerance; the receiver cannot stall.
`include "melkman_polyline_hull_core_defines.svh"
module melkman_polyline_hull_core
    import mph_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 63,
    parameter int unsigned DEQUE_DEPTH = 128
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic               last_point,
    output logic               result_valid,
    output logic signed [15:0] hull_x,
    output logic signed [15:0] hull_y,
    output logic               last_vertex,
    output logic               dropped_points
);
    localparam int unsigned AW = $clog2(DEQUE_DEPTH);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_RD_A, S_RD_B, S_MUL, S_SUB, S_DEC,
        S_PUSH_B, S_PUSH_T, S_OUT_RD, S_OUT
    } state_t;
    typedef enum logic [1:0] {
        T_BOT_CHK, T_TOP_CHK, T_BOT_POP, T_TOP_POP
    } test_t;

    state_t state_reg;
    test_t test_reg;
    logic [31:0] tol_reg;
    logic [AW-1:0] bot_reg, top_reg, idx_reg;
    logic [CW-1:0] cnt_reg;
    logic ovf_reg, last_reg, bot_skip_reg;
    logic [6:0] nout_reg, k_reg;
    point_t p_reg, a_reg, b_reg;
    point_t first_reg [4];
    logic [1:0] seed_reg;
    logic signed [33:0] m1_reg, m2_reg;
    logic signed [34:0] cr_reg;

    point_t mem [DEQUE_DEPTH];
    point_t rd_reg;
    logic we;
    logic [AW-1:0] waddr, raddr;
    point_t wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    function automatic logic [AW-1:0] up1(input logic [AW-1:0] i);
        return (i == AW'(DEQUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction
    function automatic logic [AW-1:0] dn1(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEQUE_DEPTH - 1) : i - 1'b1;
    endfunction

    logic [AW-1:0] span;
    assign span = (top_reg >= bot_reg) ? top_reg - bot_reg
                : AW'(top_reg + AW'(DEQUE_DEPTH) - bot_reg);

    logic [34:0] mag;
    logic neg_side;
    assign mag = cr_reg[34] ? 35'(-cr_reg) : cr_reg;
    assign neg_side = (mag > {3'b0, tol_reg}) && !cr_reg[34];

    logic signed [16:0] dbx, dby, dcx, dcy;
    assign dbx = 17'(signed'(b_reg[15:0])) - 17'(signed'(a_reg[15:0]));
    assign dby = 17'(signed'(b_reg[31:16])) - 17'(signed'(a_reg[31:16]));
    assign dcx = 17'(signed'(p_reg[15:0])) - 17'(signed'(a_reg[15:0]));
    assign dcy = 17'(signed'(p_reg[31:16])) - 17'(signed'(a_reg[31:16]));

    logic [AW-1:0] ra_addr;
    always_comb
    begin
        unique case (test_reg)
            T_BOT_CHK, T_BOT_POP: ra_addr = bot_reg;
            T_TOP_CHK, T_TOP_POP: ra_addr = dn1(top_reg);
            default:              ra_addr = bot_reg;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = bot_reg;
        wdata = p_reg;
        raddr = ra_addr;
        unique case (state_reg)
            S_SEED:
            begin
                we = 1'b1;
                unique case (seed_reg)
                    2'd0: begin waddr = '0; wdata = first_reg[2]; end
                    2'd1: begin waddr = AW'(3); wdata = first_reg[2]; end
                    2'd2: begin waddr = AW'(1);
                                wdata = neg_side ? first_reg[0] : first_reg[1]; end
                    default: begin waddr = AW'(2);
                                wdata = neg_side ? first_reg[1] : first_reg[0]; end
                endcase
            end
            S_RD_B: raddr = up1(ra_addr);
            S_PUSH_B: begin we = (seed_reg == 2'd1); waddr = dn1(bot_reg); end
            S_PUSH_T: begin we = 1'b1; waddr = up1(top_reg); end
            S_OUT_RD: raddr = bot_reg;
            S_OUT: raddr = idx_reg;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            test_reg <= T_BOT_CHK;
            tol_reg <= '0;
            bot_reg <= '0;
            top_reg <= AW'(3);
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            last_reg <= 1'b0;
            result_valid <= 1'b0;
            seed_reg <= '0;
            k_reg <= '0;
            nout_reg <= '0;
            bot_skip_reg <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        p_reg <= {point_y, point_x};
                        last_reg <= last_point;
                        seed_reg <= '0;
                        if (cnt_reg >= CW'(MAX_POINTS))
                        begin
                            ovf_reg <= 1'b1;
                            state_reg <= last_point ? S_OUT_RD : S_IDLE;
                        end
                        else
                        begin
                            if (cnt_reg < CW'(4))
                            begin
                                first_reg[cnt_reg[1:0]] <= {point_y, point_x};
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                            if (cnt_reg == CW'(SeedCount - 1))
                            begin
                                a_reg <= first_reg[0];
                                b_reg <= first_reg[1];
                                test_reg <= T_BOT_CHK;
                                state_reg <= S_MUL;
                            end
                            else if (cnt_reg >= CW'(SeedCount))
                            begin
                                test_reg <= T_BOT_CHK;
                                state_reg <= S_RD_A;
                            end
                            else
                            begin
                                state_reg <= last_point ? S_OUT_RD : S_IDLE;
                            end
                        end
                    end
                end
                S_RD_A: state_reg <= S_RD_B;
                S_RD_B:
                begin
                    a_reg <= rd_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (cnt_reg > CW'(SeedCount))
                    begin
                        b_reg <= rd_reg;
                    end
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    m1_reg <= cross_half(dbx, dcy);
                    m2_reg <= cross_half(dcx, dby);
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    cr_reg <= 35'(m1_reg) - 35'(m2_reg);
                    state_reg <= S_PUSH_B;
                    test_reg <= test_reg;
                    seed_reg <= 2'd3;
                end
                S_PUSH_B:
                begin
                    if (seed_reg == 2'd3)
                    begin
                        if (cnt_reg == CW'(SeedCount))
                        begin
                            seed_reg <= '0;
                            state_reg <= S_SEED;
                        end
                        else
                        begin
                            priority case (test_reg)
                                T_BOT_CHK:
                                begin
                                    bot_skip_reg <= neg_side;
                                    test_reg <= T_TOP_CHK;
                                    state_reg <= S_RD_A;
                                end
                                T_TOP_CHK:
                                begin
                                    if (bot_skip_reg && neg_side)
                                    begin
                                        state_reg <= last_reg ? S_OUT_RD : S_IDLE;
                                    end
                                    else
                                    begin
                                        test_reg <= T_BOT_POP;
                                        state_reg <= S_RD_A;
                                    end
                                end
                                T_BOT_POP:
                                begin
                                    if (span > AW'(1) && !neg_side)
                                    begin
                                        bot_reg <= up1(bot_reg);
                                        state_reg <= S_RD_A;
                                    end
                                    else
                                    begin
                                        seed_reg <= 2'd1;
                                    end
                                end
                                default:
                                begin
                                    if (span > AW'(1) && !neg_side)
                                    begin
                                        top_reg <= dn1(top_reg);
                                        state_reg <= S_RD_A;
                                    end
                                    else
                                    begin
                                        seed_reg <= 2'd2;
                                        state_reg <= S_PUSH_T;
                                    end
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        bot_reg <= dn1(bot_reg);
                        test_reg <= T_TOP_POP;
                        state_reg <= S_RD_A;
                    end
                end
                S_PUSH_T:
                begin
                    top_reg <= up1(top_reg);
                    state_reg <= last_reg ? S_OUT_RD : S_IDLE;
                end
                S_SEED:
                begin
                    seed_reg <= seed_reg + 1'b1;
                    if (seed_reg == 2'd3)
                    begin
                        bot_reg <= '0;
                        top_reg <= AW'(3);
                        state_reg <= last_reg ? S_OUT_RD : S_IDLE;
                    end
                end
                S_OUT_RD:
                begin
                    idx_reg <= up1(bot_reg);
                    k_reg <= '0;
                    if (cnt_reg < CW'(ShortRun))
                    begin
                        nout_reg <= 7'(cnt_reg);
                    end
                    else if (32'(span) + 32'd1 > 32'(ResultLimit))
                    begin
                        nout_reg <= 7'(ResultLimit);
                    end
                    else
                    begin
                        nout_reg <= 7'(span) + 7'd1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (k_reg >= nout_reg)
                    begin
                        bot_reg <= '0;
                        top_reg <= AW'(3);
                        cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        result_valid <= 1'b1;
                        {hull_y, hull_x} <= (cnt_reg < CW'(ShortRun))
                            ? first_reg[k_reg[1:0]] : rd_reg;
                        last_vertex <= (k_reg + 7'd1 == nout_reg);
                        dropped_points <= ovf_reg;
                        idx_reg <= up1(idx_reg);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `MPH_ASSERT(a_busy_out, clk, rst_n, result_valid |-> busy || $past(busy))
    `MPH_ASSERT(a_cnt_max, clk, rst_n, cnt_reg <= CW'(MAX_POINTS))
    `MPH_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !result_valid)
endmodule

// ----- tb/melkman_polyline_hull_core_tb.sv -----
// Self-checking testbench for the polyline hull core: directed and random polylines.
module melkman_polyline_hull_core_tb;
    import mph_pkg::*;

    localparam int MaxPoints = 63;
    localparam int DequeDepth = 128;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               start;
    logic               busy;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
    logic               result_valid;
    logic signed [15:0] hull_x;
    logic signed [15:0] hull_y;
    logic               last_vertex;
    logic               dropped_points;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic        dropped;
    } hull_vertex_t;

    // predictor state
    logic [31:0] tolerance;
    point_t      ring [DequeDepth];
    point_t      opening [4];
    int unsigned bot;
    int unsigned top;
    int unsigned taken;
    logic        overflowed;

    hull_vertex_t pending_hull [$];
    int           mismatches;

    melkman_polyline_hull_core #(
        .MAX_POINTS (MaxPoints),
        .DEQUE_DEPTH(DequeDepth)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .point_x       (point_x),
        .point_y       (point_y),
        .last_point    (last_point),
        .result_valid  (result_valid),
        .hull_x        (hull_x),
        .hull_y        (hull_y),
        .last_vertex   (last_vertex),
        .dropped_points(dropped_points)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int side(point_t a, point_t b, point_t c);
        longint ax;
        longint ay;
        longint cr;
        longint mag;
        ax = longint'($signed(a[15:0]));
        ay = longint'($signed(a[31:16]));
        cr = (longint'($signed(b[15:0])) - ax) * (longint'($signed(c[31:16])) - ay)
           - (longint'($signed(c[15:0])) - ax) * (longint'($signed(b[31:16])) - ay);
        mag = cr < 0 ? -cr : cr;
        if (mag <= longint'({32'd0, tolerance}))
            return 0;
        return cr > 0 ? -1 : 1;
    endfunction

    function automatic int unsigned nxt(int unsigned i);
        return (i + 1) % DequeDepth;
    endfunction

    function automatic int unsigned prv(int unsigned i);
        return (i + DequeDepth - 1) % DequeDepth;
    endfunction

    function automatic int unsigned spread();
        return (top + DequeDepth - bot) % DequeDepth;
    endfunction

    task automatic clear_hull_run();
        bot = 0;
        top = SeedCount % DequeDepth;
        taken = 0;
        overflowed = 1'b0;
    endtask

    task automatic grow_hull(point_t p);
        if (side(ring[bot], ring[nxt(bot)], p) < 0 && side(ring[prv(top)], ring[top], p) < 0)
            return;
        while (spread() > 1 && side(ring[bot], ring[nxt(bot)], p) >= 0)
            bot = nxt(bot);
        bot = prv(bot);
        ring[bot] = p;
        while (spread() > 1 && side(ring[prv(top)], ring[top], p) >= 0)
            top = prv(top);
        top = nxt(top);
        ring[top] = p;
    endtask

    task automatic predict_hull(point_t p, logic fin);
        int unsigned n;
        int unsigned idx;
        point_t      v;
        hull_vertex_t e;
        if (taken >= MaxPoints)
            overflowed = 1'b1;
        else
        begin
            if (taken < 4)
                opening[taken] = p;
            taken++;
            if (taken == SeedCount)
            begin
                bot = 0;
                top = SeedCount % DequeDepth;
                ring[0] = opening[2];
                ring[top] = opening[2];
                if (side(opening[0], opening[1], opening[2]) < 0)
                begin
                    ring[1] = opening[0];
                    ring[2] = opening[1];
                end
                else
                begin
                    ring[1] = opening[1];
                    ring[2] = opening[0];
                end
            end
            else if (taken > SeedCount)
                grow_hull(p);
        end
        if (!fin)
            return;
        if (taken < ShortRun)
            n = taken;
        else
        begin
            n = spread() + 1;
            if (n > ResultLimit)
                n = ResultLimit;
        end
        idx = bot;
        for (int unsigned k = 0; k < n; k++)
        begin
            if (taken < ShortRun)
                v = opening[k & 3];
            else
            begin
                v = ring[idx];
                idx = nxt(idx);
            end
            e.x = v[15:0];
            e.y = v[31:16];
            e.last = (k + 1 == n);
            e.dropped = overflowed;
            pending_hull.push_back(e);
        end
        clear_hull_run();
    endtask

    // result checker
    always @(posedge clk)
    begin
        hull_vertex_t e;
        if (rst_n && result_valid)
        begin
            if (pending_hull.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected hull vertex x=%0d y=%0d", hull_x, hull_y);
            end
            else
            begin
                e = pending_hull.pop_front();
                if (e.x !== hull_x || e.y !== hull_y || e.last !== last_vertex
                    || e.dropped !== dropped_points)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hull mismatch: exp x=%0d y=%0d l=%0b d=%0b got x=%0d y=%0d l=%0b d=%0b",
                                 $signed(e.x), $signed(e.y), e.last, e.dropped,
                                 hull_x, hull_y, last_vertex, dropped_points);
                end
            end
        end
    end

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic fin, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_x <= x;
        point_y <= y;
        last_point <= fin;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_hull({y, x}, fin);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_hull.size() != 0 || busy)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_tolerance(logic [31:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        tolerance = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_polyline(int len, int span_max, bit gaps);
        for (int i = 0; i < len; i++)
            send_point(16'($urandom_range(0, 2 * span_max) - span_max),
                       16'($urandom_range(0, 2 * span_max) - span_max), i == len - 1, gaps);
    endtask

    task automatic test_short_runs();
        send_point(16'h7FFF, 16'h8000, 1'b1, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        send_point(16'h0000, 16'hFFFF, 1'b1, 1'b0);
        send_point(16'd1, 16'd2, 1'b0, 1'b0);
        send_point(16'd3, 16'd4, 1'b0, 1'b0);
        send_point(16'd5, 16'd1, 1'b1, 1'b0);
        send_polyline(4, 100, 1'b0);
    endtask

    task automatic test_square_and_collinear();
        send_point(16'd0, 16'd0, 1'b0, 1'b0);
        send_point(16'd100, 16'd0, 1'b0, 1'b0);
        send_point(16'd100, 16'd100, 1'b0, 1'b0);
        send_point(16'd0, 16'd100, 1'b0, 1'b0);
        send_point(16'd50, 16'd50, 1'b0, 1'b0);
        send_point(16'd0, 16'd0, 1'b0, 1'b0);
        send_point(16'd0, 16'd0, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++)
            send_point(16'(i * 10), 16'(i * 10), i == 5, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
        send_point(16'h7FFF, 16'h8000, 1'b0, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0, 1'b0);
        send_point(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1, 1'b0);
    endtask

    task automatic test_overflow();
        send_polyline(MaxPoints + 4, 32768, 1'b0);
    endtask

    task automatic test_random_polylines();
        int sent;
        int len;
        sent = 0;
        while (sent < 25)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            send_polyline(len, ($urandom_range(0, 1) != 0) ? 32768 : 64, $urandom_range(0, 3) != 0);
            sent += len;
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        point_x = '0;
        point_y = '0;
        last_point = 1'b0;
        mismatches = 0;
        tolerance = '0;
        clear_hull_run();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_short_runs();
        test_square_and_collinear();
        set_tolerance(32'd200);
        test_square_and_collinear();
        set_tolerance(32'hFFFFFFFF);
        test_square_and_collinear();
        test_overflow();
        set_tolerance(32'd0);
        test_overflow();
        test_random_polylines();
        set_tolerance(32'd5000);
        test_random_polylines();
        set_tolerance(32'd0);
        drain_results();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- melkman_polyline_hull_core.f -----
+incdir+rtl
rtl/mph_pkg.sv
rtl/melkman_polyline_hull_core.sv
tb/melkman_polyline_hull_core_tb.sv
